// ===== design/cb32_pkg.sv =====
// shared types, tables and helpers for the checked base-32 state codec
// used by the encoder, the decoder and the top level; no dependencies

package cb32_pkg;

  localparam int unsigned StateW = 16;
  localparam int unsigned HashW  = 9;
  localparam int unsigned CheckW = 5;
  localparam int unsigned DigitW = 5;
  localparam int unsigned NumChars = 6;
  localparam int unsigned WordW  = DigitW * NumChars;
  localparam int unsigned InCharW  = 8;
  localparam int unsigned OutCharW = 7;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_MISMATCH = 2'd1,
    STAT_ILLEGAL  = 2'd2
  } status_e;

  typedef struct packed {
    status_e                               status;
    logic [StateW-1:0]                     state;
    logic [NumChars-1:0][OutCharW-1:0]     chars;
  } result_t;

  // bit positions in the 30-bit code word
  localparam logic [4:0] PosC [CheckW] = '{5'd20, 5'd15, 5'd10, 5'd5, 5'd0};
  localparam logic [4:0] PosH [HashW]  =
    '{5'd1, 5'd6, 5'd11, 5'd16, 5'd21, 5'd25, 5'd2, 5'd7, 5'd26};
  localparam logic [4:0] PosS [StateW] =
    '{5'd29, 5'd24, 5'd19, 5'd14, 5'd9, 5'd4, 5'd28, 5'd23,
      5'd18, 5'd13, 5'd8, 5'd3, 5'd27, 5'd22, 5'd17, 5'd12};

  // ABCDEFGHIJKLMNOPQRSTUVWXYZ134679
  localparam logic [OutCharW-1:0] Alphabet [32] =
    '{7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46, 7'h47, 7'h48,
      7'h49, 7'h4a, 7'h4b, 7'h4c, 7'h4d, 7'h4e, 7'h4f, 7'h50,
      7'h51, 7'h52, 7'h53, 7'h54, 7'h55, 7'h56, 7'h57, 7'h58,
      7'h59, 7'h5a, 7'h31, 7'h33, 7'h34, 7'h36, 7'h37, 7'h39};

  function automatic logic [HashW-1:0] hash9(input logic [StateW-1:0] s);
    return ~({s[15:8], 1'b0} ^ {1'b0, s[7:0]});
  endfunction

  function automatic logic [CheckW-1:0] ones_sum(input logic [HashW-1:0] h,
                                                 input logic [StateW-1:0] s);
    return CheckW'($countones(h)) + CheckW'($countones(s));
  endfunction

endpackage

// ===== design/cb32_encoder.sv =====
// state word to six-character password, pure combinational
// depends on cb32_pkg

module cb32_encoder (
  input  logic [cb32_pkg::StateW-1:0] state_i,
  output cb32_pkg::result_t           result_o
);

  logic [cb32_pkg::HashW-1:0]  hash;
  logic [cb32_pkg::CheckW-1:0] check;
  logic [cb32_pkg::WordW-1:0]  word;

  assign hash  = cb32_pkg::hash9(state_i);
  assign check = cb32_pkg::CheckW'(0) - cb32_pkg::ones_sum(hash, state_i);

  always_comb begin
    word = '0;
    for (int i = 0; i < cb32_pkg::CheckW; i++) word[cb32_pkg::PosC[i]] = check[i];
    for (int i = 0; i < cb32_pkg::HashW; i++)  word[cb32_pkg::PosH[i]] = hash[i];
    for (int i = 0; i < cb32_pkg::StateW; i++) word[cb32_pkg::PosS[i]] = state_i[i];
  end

  always_comb begin
    result_o.status = cb32_pkg::STAT_OK;
    result_o.state  = '0;
    for (int i = 0; i < cb32_pkg::NumChars; i++) begin
      result_o.chars[i] = cb32_pkg::Alphabet[word[cb32_pkg::DigitW*i +: cb32_pkg::DigitW]];
    end
  end

endmodule

// ===== design/cb32_decoder.sv =====
// six-character password to state word with check and hash verify
// depends on cb32_pkg

module cb32_decoder (
  input  logic [cb32_pkg::NumChars-1:0][cb32_pkg::InCharW-1:0] chars_i,
  output cb32_pkg::result_t                                     result_o
);

  // returns {illegal, digit}
  function automatic logic [cb32_pkg::DigitW:0] char_digit(
    input logic [cb32_pkg::InCharW-1:0] ch_in
  );
    logic [cb32_pkg::InCharW-1:0] ch;
    logic [cb32_pkg::DigitW:0]    res;
    ch = ch_in;
    if (ch >= 8'h61 && ch <= 8'h7a) ch = ch - 8'h20;
    unique case (ch)
      8'h30:   ch = 8'h4f;
      8'h32:   ch = 8'h5a;
      8'h35:   ch = 8'h53;
      8'h38:   ch = 8'h42;
      default: ch = ch;
    endcase
    if (ch >= 8'h41 && ch <= 8'h5a) begin
      res = {1'b0, 5'(ch - 8'h41)};
    end else begin
      unique case (ch)
        8'h31:   res = {1'b0, 5'd26};
        8'h33:   res = {1'b0, 5'd27};
        8'h34:   res = {1'b0, 5'd28};
        8'h36:   res = {1'b0, 5'd29};
        8'h37:   res = {1'b0, 5'd30};
        8'h39:   res = {1'b0, 5'd31};
        default: res = {1'b1, 5'd0};
      endcase
    end
    return res;
  endfunction

  logic [cb32_pkg::NumChars-1:0] illegal;
  logic [cb32_pkg::WordW-1:0]    word;
  logic [cb32_pkg::CheckW-1:0]   check;
  logic [cb32_pkg::HashW-1:0]    hash;
  logic [cb32_pkg::StateW-1:0]   state;
  logic                          sum_ok;
  logic                          hash_ok;

  always_comb begin
    logic [cb32_pkg::DigitW:0] d;
    for (int i = 0; i < cb32_pkg::NumChars; i++) begin
      d = char_digit(chars_i[i]);
      illegal[i] = d[cb32_pkg::DigitW];
      word[cb32_pkg::DigitW*i +: cb32_pkg::DigitW] = d[cb32_pkg::DigitW-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < cb32_pkg::CheckW; i++) check[i] = word[cb32_pkg::PosC[i]];
    for (int i = 0; i < cb32_pkg::HashW; i++)  hash[i]  = word[cb32_pkg::PosH[i]];
    for (int i = 0; i < cb32_pkg::StateW; i++) state[i] = word[cb32_pkg::PosS[i]];
  end

  assign sum_ok  = (check + cb32_pkg::ones_sum(hash, state)) == '0;
  assign hash_ok = hash == cb32_pkg::hash9(state);

  always_comb begin
    result_o.chars = '0;
    result_o.state = '0;
    priority if (|illegal) begin
      result_o.status = cb32_pkg::STAT_ILLEGAL;
    end else if (!sum_ok || !hash_ok) begin
      result_o.status = cb32_pkg::STAT_MISMATCH;
    end else begin
      result_o.status = cb32_pkg::STAT_OK;
      result_o.state  = state;
    end
  end

endmodule

// ===== design/checked_base32_state_codec_core.sv =====
// Checked base-32 state codec: one request per cycle while the output is not stalled,
// one result per request. A request is registered on acceptance, encoded or decoded in
// a single pass of combinational logic and registered again as the result; an output
// stall can hold it in the input register before it reaches the result register. The
// input register takes the next request while a result waits, if it is empty. tuser
// selects the operation on the input side and carries the status on the output side.
// Depends on cb32_pkg, cb32_encoder and cb32_decoder.

module checked_base32_state_codec_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // state_in[15:0], char_0..char_5 [63:16] (8 bits each)
  input  logic [63:0] s_axis_tdata,
  // req_type[0]
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // state_out[15:0], out_char_0..out_char_5 [57:16] (7 bits each), zero fill
  output logic [63:0] m_axis_tdata,
  // status[1:0]
  output logic [1:0]  m_axis_tuser
);

  logic                  in_valid_q;
  logic                  req_type_q;
  logic [63:0]           in_data_q;
  logic                  out_valid_q;
  cb32_pkg::result_t     res_q;
  cb32_pkg::result_t     res_d;
  cb32_pkg::result_t     enc_res;
  cb32_pkg::result_t     dec_res;
  logic                  out_free;
  logic                  in_adv;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign in_adv        = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      req_type_q <= s_axis_tuser[0];
      in_data_q  <= s_axis_tdata;
    end
  end

  cb32_encoder u_encoder (
    .state_i  (in_data_q[15:0]),
    .result_o (enc_res)
  );

  cb32_decoder u_decoder (
    .chars_i  (in_data_q[63:16]),
    .result_o (dec_res)
  );

  assign res_d = req_type_q ? dec_res : enc_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, res_q.chars, res_q.state};
  assign m_axis_tuser  = res_q.status;

  // a held request is not dropped while the result side stalls
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_free) |=> in_valid_q)
    else $error("request lost under stall");

  // a finished request reaches the output in the next cycle
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_adv |=> out_valid_q)
    else $error("result not presented");

  // failed decodes carry no state and no characters
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.status != cb32_pkg::STAT_OK) |->
      (res_q.state == '0 && res_q.chars == '0))
    else $error("payload on failed decode");

  // a result never holds both a state and characters
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.state != '0) |-> res_q.chars == '0)
    else $error("mixed encode and decode payload");

endmodule

// ===== sim/testbench.sv =====
// stream-level testbench for checked_base32_state_codec_core: encode and decode requests
// checked against an in-bench codec model; needs cb32_pkg and the core rtl

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic REQ_ENCODE = 1'b0;
  localparam logic REQ_DECODE = 1'b1;
  localparam logic [5:0] NO_DIGIT = 6'd32;
  localparam int RANDOM_REQS = 1600;
  localparam int HOLD_CYCLES = 64;

  localparam logic [8*32-1:0] LETTERS = "ABCDEFGHIJKLMNOPQRSTUVWXYZ134679";
  localparam int CHK_POS [5] = '{20, 15, 10, 5, 0};
  localparam int HASH_POS [9] = '{1, 6, 11, 16, 21, 25, 2, 7, 26};
  localparam int STATE_POS [16] =
    '{29, 24, 19, 14, 9, 4, 28, 23, 18, 13, 8, 3, 27, 22, 17, 12};

  typedef struct packed {
    cb32_pkg::status_e status;
    logic [15:0]       state;
    logic [5:0][6:0]   chars;
  } codec_res_t;

  typedef struct {
    logic              req;
    logic [15:0]       state;
    logic [47:0]       text;
    bit                typed;
    cb32_pkg::status_e status;
    logic [15:0]       dec_state;
  } plan_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic [0:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  codec_res_t pending_results [$];
  int         fail_count = 0;
  int         rnd_idx = -1;
  bit         tx_steady = 1'b0;
  bit         hold_req = 1'b0;
  plan_row_t  plan [23];

  checked_base32_state_codec_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int unsigned count_ones(input logic [31:0] v);
    int unsigned n;
    n = 0;
    for (int i = 0; i < 32; i++) n += v[i];
    return n;
  endfunction

  function automatic logic [8:0] state_hash(input logic [15:0] s);
    logic [8:0] hi;
    logic [8:0] lo;
    hi = {s[15:8], 1'b0};
    lo = {1'b0, s[7:0]};
    return ~(hi ^ lo);
  endfunction

  function automatic logic [7:0] letter_of(input logic [4:0] d);
    return LETTERS[8*(31-d) +: 8];
  endfunction

  function automatic logic [5:0] char_digit(input logic [7:0] ch);
    logic [7:0] c;
    c = ch;
    if (c >= "a" && c <= "z") c = c - 8'h20;
    case (c)
      "0": c = "O";
      "2": c = "Z";
      "5": c = "S";
      "8": c = "B";
      default: ;
    endcase
    for (int i = 0; i < 32; i++) if (letter_of(5'(i)) == c) return 6'(i);
    return NO_DIGIT;
  endfunction

  function automatic codec_res_t codec_predict(input logic req, input logic [63:0] data);
    codec_res_t  r;
    logic [15:0] s;
    logic [8:0]  h;
    logic [4:0]  c;
    logic [29:0] w;
    logic [5:0]  d;
    bit          bad;
    r = '0;
    w = '0;
    if (req == REQ_ENCODE) begin
      s = data[15:0];
      h = state_hash(s);
      c = 5'(32 - count_ones(32'(h)) - count_ones(32'(s)));
      for (int i = 0; i < 5; i++) if (c[i]) w[CHK_POS[i]] = 1'b1;
      for (int i = 0; i < 9; i++) if (h[i]) w[HASH_POS[i]] = 1'b1;
      for (int i = 0; i < 16; i++) if (s[i]) w[STATE_POS[i]] = 1'b1;
      for (int i = 0; i < 6; i++) r.chars[i] = 7'(letter_of(w[5*i +: 5]));
      r.status = cb32_pkg::STAT_OK;
    end else begin
      bad = 1'b0;
      for (int i = 0; i < 6; i++) begin
        d = char_digit(data[16+8*i +: 8]);
        if (d[5]) bad = 1'b1;
        else w[5*i +: 5] = d[4:0];
      end
      if (bad) begin
        r.status = cb32_pkg::STAT_ILLEGAL;
      end else begin
        c = '0;
        h = '0;
        s = '0;
        for (int i = 0; i < 5; i++) c[i] = w[CHK_POS[i]];
        for (int i = 0; i < 9; i++) h[i] = w[HASH_POS[i]];
        for (int i = 0; i < 16; i++) s[i] = w[STATE_POS[i]];
        if (5'(c + count_ones(32'(h)) + count_ones(32'(s))) != 5'd0 || h != state_hash(s)) begin
          r.status = cb32_pkg::STAT_MISMATCH;
        end else begin
          r.status = cb32_pkg::STAT_OK;
          r.state = s;
        end
      end
    end
    return r;
  endfunction

  // first character of the text sits in the low byte
  function automatic logic [47:0] pack_text(input logic [47:0] t);
    logic [47:0] p;
    for (int i = 0; i < 6; i++) p[8*i +: 8] = t[8*(5-i) +: 8];
    return p;
  endfunction

  task automatic send_request(input logic req, input logic [63:0] data, input bit typed,
                              input codec_res_t typed_res);
    while (!tx_steady && $urandom_range(99) < 17) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = data;
    s_axis_tuser = req;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(typed ? typed_res : codec_predict(req, data));
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid = 1'b0;
    @(negedge clk_i);
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic check_result(input codec_res_t exp_r);
    if (m_axis_tuser !== exp_r.status) begin
      $display("%0t: status expected %0d, got %0d", $time, exp_r.status, m_axis_tuser);
      fail_count++;
    end
    if (m_axis_tdata[15:0] !== exp_r.state) begin
      $display("%0t: state_out expected %h, got %h", $time, exp_r.state, m_axis_tdata[15:0]);
      fail_count++;
    end
    for (int i = 0; i < 6; i++) begin
      if (m_axis_tdata[16+7*i +: 7] !== exp_r.chars[i]) begin
        $display("%0t: out_char_%0d expected %h, got %h", $time, i, exp_r.chars[i],
                 m_axis_tdata[16+7*i +: 7]);
        fail_count++;
      end
    end
    if (m_axis_tdata[63:58] !== 6'd0) begin
      $display("%0t: fill expected 0, got %h", $time, m_axis_tdata[63:58]);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result expected none, got tuser %h tdata %h", $time, m_axis_tuser,
                 m_axis_tdata);
        fail_count++;
      end else begin
        check_result(pending_results.pop_front());
      end
    end
  end

  // receiver side: random stalls, one long hold-off, one steady stretch
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else if (rnd_idx >= 650 && rnd_idx < 950) begin
        m_axis_tready = 1'b1;
      end else begin
        m_axis_tready = ($urandom_range(99) >= 17);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    codec_res_t  typed_res;
    codec_res_t  enc;
    logic [47:0] text;
    logic [7:0]  ch;
    logic [15:0] st;
    int unsigned r;
    int unsigned pick;

    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = REQ_ENCODE;

    plan = '{
      '{REQ_ENCODE, 16'h0000, "zzzzzz", 1'b0, cb32_pkg::STAT_OK, 16'h0},
      '{REQ_ENCODE, 16'hffff, "ZZZZZZ", 1'b0, cb32_pkg::STAT_OK, 16'h0},
      '{REQ_ENCODE, 16'h00ff, "AAAAAA", 1'b0, cb32_pkg::STAT_OK, 16'h0},
      '{REQ_ENCODE, 16'hff00, "999999", 1'b0, cb32_pkg::STAT_OK, 16'h0},
      '{REQ_ENCODE, 16'h5555, "HGDDDD", 1'b0, cb32_pkg::STAT_OK, 16'h0},
      '{REQ_ENCODE, 16'haaaa, "hgdddd", 1'b0, cb32_pkg::STAT_OK, 16'h0},
      '{REQ_ENCODE, 16'h8001, "O2S5B8", 1'b0, cb32_pkg::STAT_OK, 16'h0},
      '{REQ_DECODE, 16'hffff, "AAAAAA", 1'b1, cb32_pkg::STAT_MISMATCH, 16'h0},
      '{REQ_DECODE, 16'h0000, "999999", 1'b0, cb32_pkg::STAT_OK, 16'h0},
      '{REQ_DECODE, 16'h0000, "HGDDDD", 1'b1, cb32_pkg::STAT_OK, 16'h0},
      '{REQ_DECODE, 16'h0000, "hgdddd", 1'b1, cb32_pkg::STAT_OK, 16'h0},
      '{REQ_DECODE, 16'h0000, "134679", 1'b0, cb32_pkg::STAT_OK, 16'h0},
      '{REQ_DECODE, 16'h0000, "O2S5B8", 1'b0, cb32_pkg::STAT_OK, 16'h0},
      '{REQ_DECODE, 16'h0000, "0258ab", 1'b0, cb32_pkg::STAT_OK, 16'h0},
      '{REQ_DECODE, 16'h0000, {8'h00, "GDDDD"}, 1'b1, cb32_pkg::STAT_ILLEGAL, 16'h0},
      '{REQ_DECODE, 16'h0000, {"HGDDD", 8'hff}, 1'b1, cb32_pkg::STAT_ILLEGAL, 16'h0},
      '{REQ_DECODE, 16'h0000, {"HG", 8'h80, "DDD"}, 1'b1, cb32_pkg::STAT_ILLEGAL, 16'h0},
      '{REQ_DECODE, 16'h0000, "HG@DDD", 1'b1, cb32_pkg::STAT_ILLEGAL, 16'h0},
      '{REQ_DECODE, 16'h0000, "HGD[DD", 1'b1, cb32_pkg::STAT_ILLEGAL, 16'h0},
      '{REQ_DECODE, 16'h0000, "HGDD`D", 1'b1, cb32_pkg::STAT_ILLEGAL, 16'h0},
      '{REQ_DECODE, 16'h0000, "HGDDD{", 1'b1, cb32_pkg::STAT_ILLEGAL, 16'h0},
      '{REQ_DECODE, 16'h0000, "H DDDD", 1'b1, cb32_pkg::STAT_ILLEGAL, 16'h0},
      '{REQ_DECODE, 16'h0000, "HGDD2D", 1'b0, cb32_pkg::STAT_OK, 16'h0}
    };

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (plan[k]) begin
      typed_res = '0;
      typed_res.status = plan[k].status;
      typed_res.state = plan[k].dec_state;
      send_request(plan[k].req, {pack_text(plan[k].text), plan[k].state}, plan[k].typed,
                   typed_res);
    end
    drain_results();

    typed_res = '0;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      rnd_idx = n;
      tx_steady = (n >= 500 && n < 800);
      if (n == 150) hold_req = 1'b1;
      if (n == 1000) drain_results();
      r = $urandom_range(99);
      if (r < 40) begin
        st = 16'($urandom);
        pick = $urandom_range(9);
        if (pick == 0) st = 16'h0000;
        else if (pick == 1) st = 16'hffff;
        else if (pick == 2) st = 16'h1 << $urandom_range(15);
        send_request(REQ_ENCODE, {$urandom, 16'($urandom), st}, 1'b0, typed_res);
      end else if (r < 85) begin
        // encoded password with case and look-alike digit variants, at times with one character replaced
        enc = codec_predict(REQ_ENCODE, {48'h0, 16'($urandom)});
        for (int i = 0; i < 6; i++) begin
          ch = {1'b0, enc.chars[i]};
          pick = $urandom_range(99);
          if (pick < 25 && ch >= "A" && ch <= "Z") begin
            ch = ch | 8'h20;
          end else if (pick < 50) begin
            case (ch)
              "O": ch = "0";
              "Z": ch = "2";
              "S": ch = "5";
              "B": ch = "8";
              default: ;
            endcase
          end
          text[8*i +: 8] = ch;
        end
        if ($urandom_range(99) < 12) begin
          pick = $urandom_range(5);
          text[8*pick +: 8] = letter_of(5'($urandom_range(31)));
        end
        send_request(REQ_DECODE, {text, 16'($urandom)}, 1'b0, typed_res);
      end else begin
        for (int i = 0; i < 6; i++) begin
          if (r < 92) text[8*i +: 8] = 8'($urandom);
          else text[8*i +: 8] = letter_of(5'($urandom_range(31)));
        end
        send_request(REQ_DECODE, {text, 16'($urandom)}, 1'b0, typed_res);
      end
    end
    tx_steady = 1'b0;

    drain_results();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
